[hw/rtl/matmul_tile_outer_product_accumulate_assert.svh]
// Assertion macros shared by the tile accumulator RTL.
// Each check is sampled on clk and is off while arst_n is low.
`ifndef MATMUL_TILE_OUTER_PRODUCT_ACCUMULATE_ASSERT_SVH
`define MATMUL_TILE_OUTER_PRODUCT_ACCUMULATE_ASSERT_SVH

// same-cycle implication
`define MTOPA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MTOPA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/mtopa_pkg.sv]
`timescale 1ns / 1ps

package mtopa_pkg;

	localparam int TILE_ROWS_DEF = 8;
	localparam int TILE_COLS_DEF = 8;
	localparam int LANE_W        = 16;
	localparam int PROD_W        = 2 * LANE_W;
	localparam int ACC_W         = 48;

	localparam logic REQ_KSTEP = 1'b0;
	localparam logic REQ_MERGE = 1'b1;

	typedef struct packed {
		logic               req_type;
		logic               first_step;
		logic [63:0]        a_rows_low;
		logic [63:0]        a_rows_high;
		logic [63:0]        b_cols_low;
		logic [63:0]        b_cols_high;
		logic [2:0]         row;
		logic [2:0]         col;
		logic [3:0]         active_rows;
		logic [3:0]         active_cols;
		logic signed [47:0] c_old;
	} req_t;

	typedef struct packed {
		logic signed [47:0] c_new;
		logic               in_range;
		logic               saturated;
	} rsp_t;

	// control into the row multiply-accumulate unit
	typedef struct packed {
		logic issue;
		logic zero_base;
	} mac_ctl_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] val;
		logic                    clip;
	} sat_t;

	// clip a one-bit-grown sum back into the accumulator range
	function automatic sat_t sat_acc(input logic signed [ACC_W:0] sum);
		sat_t r;
		r.clip = sum[ACC_W] != sum[ACC_W-1];
		r.val  = r.clip ? {sum[ACC_W], {(ACC_W-1){~sum[ACC_W]}}} : sum[ACC_W-1:0];
		return r;
	endfunction

endpackage

[hw/rtl/mtopa_row_mac.sv]
`timescale 1ns / 1ps

module mtopa_row_mac import mtopa_pkg::*; #(
	parameter int TILE_COLS = TILE_COLS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mac_ctl_t                     ctl,
	input  logic [LANE_W-1:0]            a_lane,
	input  logic [TILE_COLS*LANE_W-1:0]  b_lanes,
	input  logic [TILE_COLS*ACC_W-1:0]   acc_row,
	output logic                         sum_valid,
	output logic [TILE_COLS*ACC_W-1:0]   sum_row
);

	mac_ctl_t                  ctl_s1;
	logic signed [PROD_W-1:0]  prod_s1 [TILE_COLS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	// one multiplier per column; registered products meet the registered row read data in the cycle after issue
	always_ff @(posedge clk) begin
		if (ctl.issue) begin
			for (int n = 0; n < TILE_COLS; n++) begin
				prod_s1[n] <= $signed(a_lane) * $signed(b_lanes[n*LANE_W +: LANE_W]);
			end
		end
	end

	always_comb begin
		logic signed [ACC_W-1:0] base;
		logic signed [ACC_W:0]   sum;
		sat_t                    s;
		sum_row = '0;
		for (int n = 0; n < TILE_COLS; n++) begin
			base = ctl_s1.zero_base ? '0 : $signed(acc_row[n*ACC_W +: ACC_W]);
			sum  = {base[ACC_W-1], base}
				+ {{(ACC_W+1-PROD_W){prod_s1[n][PROD_W-1]}}, prod_s1[n]};
			s    = sat_acc(sum);
			sum_row[n*ACC_W +: ACC_W] = s.val;
		end
	end

	assign sum_valid = ctl_s1.issue;

endmodule

[hw/rtl/matmul_tile_outer_product_accumulate.sv]
// k-step: accepted, then one accumulator row per cycle through TILE_COLS multipliers,
//   all TILE_ROWS rows in turn; next request taken once the last row has issued.
// merge: one row read (ST_MRD), result registered in ST_MOUT once the output is free.
// Rate is set by the row-wide accumulator memory, one read and one write port (one row read per cycle).
// Reset clears per-row valid bits; unwritten rows read as zero, no clearing pass.
`timescale 1ns / 1ps
`include "matmul_tile_outer_product_accumulate_assert.svh"

module matmul_tile_outer_product_accumulate import mtopa_pkg::*; #(
	parameter int TILE_ROWS = TILE_ROWS_DEF,
	parameter int TILE_COLS = TILE_COLS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int RIW   = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;
	localparam int ROW_W = TILE_COLS * ACC_W;

	typedef enum logic [1:0] {ST_IDLE, ST_STEP, ST_MRD, ST_MOUT} state_t;

	state_t                  state_q;
	logic [RIW-1:0]          row_q;
	logic                    rsp_valid_q;
	rsp_t                    rsp_q;

	logic                    clr_q;
	logic [127:0]            a_q;
	logic [127:0]            b_q;
	logic [2:0]              mrow_q;
	logic [2:0]              mcol_q;
	logic                    inr_q;
	logic signed [ACC_W-1:0] c_old_q;

	logic [ROW_W-1:0]        acc_mem [TILE_ROWS];
	logic [ROW_W-1:0]        rd_data_s1;
	logic [TILE_ROWS-1:0]    row_vld_q;
	logic [RIW-1:0]          wr_row_s1;

	logic                    req_acc;
	logic                    issue;
	logic                    rd_en;
	logic [RIW-1:0]          rd_addr;
	logic [RIW-1:0]          mrow_idx;
	logic                    wr_en;
	logic [ROW_W-1:0]        sum_row;
	mac_ctl_t                mac_ctl;
	logic [3:0]              ar_eff;
	logic [3:0]              ac_eff;
	logic                    inr;
	logic                    out_free;
	logic signed [ACC_W-1:0] macc;
	logic signed [ACC_W:0]   msum;
	sat_t                    msat;

	assign req_stall = state_q != ST_IDLE;
	assign req_acc   = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// active counts above the tile size act as the tile size
	assign ar_eff = (req.active_rows > 4'(TILE_ROWS)) ? 4'(TILE_ROWS) : req.active_rows;
	assign ac_eff = (req.active_cols > 4'(TILE_COLS)) ? 4'(TILE_COLS) : req.active_cols;
	assign inr    = ({1'b0, req.row} < ar_eff) && ({1'b0, req.col} < ac_eff);

	assign issue    = state_q == ST_STEP;
	assign mrow_idx = inr_q ? mrow_q[RIW-1:0] : '0;
	assign rd_en    = issue || (state_q == ST_MRD);
	assign rd_addr  = issue ? row_q : mrow_idx;

	assign mac_ctl.issue     = issue;
	assign mac_ctl.zero_base = clr_q || !row_vld_q[row_q];

	mtopa_row_mac #(
		.TILE_COLS (TILE_COLS)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (mac_ctl),
		.a_lane    (a_q[row_q*LANE_W +: LANE_W]),
		.b_lanes   (b_q[TILE_COLS*LANE_W-1:0]),
		.acc_row   (rd_data_s1),
		.sum_valid (wr_en),
		.sum_row   (sum_row)
	);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			acc_mem[wr_row_s1] <= sum_row;
		end
		if (rd_en) begin
			rd_data_s1 <= acc_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			wr_row_s1 <= row_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (wr_en) begin
			row_vld_q[wr_row_s1] <= 1'b1;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (req_acc) begin
			clr_q   <= req.first_step;
			a_q     <= {req.a_rows_high, req.a_rows_low};
			b_q     <= {req.b_cols_high, req.b_cols_low};
			mrow_q  <= req.row;
			mcol_q  <= req.col;
			inr_q   <= inr;
			c_old_q <= req.c_old;
		end
	end

	// merge: pick the column, add, clip
	always_comb begin
		macc = '0;
		for (int n = 0; n < TILE_COLS; n++) begin
			if (mcol_q == 3'(n) && row_vld_q[mrow_idx]) begin
				macc = $signed(rd_data_s1[n*ACC_W +: ACC_W]);
			end
		end
		msum = {c_old_q[ACC_W-1], c_old_q} + {macc[ACC_W-1], macc};
		msat = sat_acc(msum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			// in ST_MOUT the output register is reloaded below
			if (rsp_valid_q && !rsp_stall && state_q != ST_MOUT) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					row_q <= '0;
					if (req_acc) begin
						state_q <= (req.req_type == REQ_MERGE) ? ST_MRD : ST_STEP;
					end
				end
				ST_STEP: begin
					row_q <= row_q + 1'b1;
					if (row_q == RIW'(TILE_ROWS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_MRD: begin
					state_q <= ST_MOUT;
				end
				ST_MOUT: begin
					if (out_free) begin
						rsp_valid_q     <= 1'b1;
						rsp_q.c_new     <= inr_q ? msat.val : c_old_q;
						rsp_q.in_range  <= inr_q;
						rsp_q.saturated <= inr_q && msat.clip;
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`MTOPA_ASSERT_NOW(a_no_rw_same_row, wr_en && rd_en, wr_row_s1 != rd_addr, "row r/w clash")
	`MTOPA_ASSERT_NEXT(a_issue_writes_back, issue, wr_en, "issued row not written back")
	`MTOPA_ASSERT_NOW(a_oor_clean, rsp_valid && !rsp.in_range, !rsp.saturated, "stray sat")

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import mtopa_pkg::*;

	localparam int     RAND_PER_PHASE = 370;
	localparam int     CYCLE_LIMIT    = 400000;
	localparam int     SETTLE_CYCLES  = 16;
	localparam longint ACC_HI         = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint ACC_LO         = -ACC_HI - 1;
	localparam logic signed [47:0] C_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] C_MIN = 48'sh8000_0000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	req_t request_q[$];
	rsp_t merge_results_q[$];
	logic signed [47:0] tile_acc [64];
	int send_idle_pct = 0;
	int rcv_stall_pct = 0;
	int mismatch_cnt = 0;
	int cycle_cnt = 0;

	matmul_tile_outer_product_accumulate i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------- tile predictor ----------------

	function automatic logic signed [15:0] lane_of(input logic [63:0] lo, input logic [63:0] hi,
			input int idx);
		logic [63:0] word;
		word = (idx < 4) ? lo : hi;
		return word[(idx % 4) * 16 +: 16];
	endfunction

	function automatic logic signed [47:0] clip48(input longint v, output bit hit);
		hit = 1'b0;
		if (v > ACC_HI) begin
			hit = 1'b1;
			return C_MAX;
		end
		if (v < ACC_LO) begin
			hit = 1'b1;
			return C_MIN;
		end
		return v[47:0];
	endfunction

	task automatic apply_to_tile(input req_t r);
		longint a;
		longint b;
		longint sum;
		int ar;
		int ac;
		bit hit;
		rsp_t res;
		if (r.req_type == REQ_KSTEP) begin
			if (r.first_step)
				foreach (tile_acc[i]) tile_acc[i] = '0;
			for (int m = 0; m < TILE_ROWS_DEF; m++) begin
				a = lane_of(r.a_rows_low, r.a_rows_high, m);
				for (int n = 0; n < TILE_COLS_DEF; n++) begin
					b = lane_of(r.b_cols_low, r.b_cols_high, n);
					sum = tile_acc[m * 8 + n];
					tile_acc[m * 8 + n] = clip48(sum + a * b, hit);
				end
			end
		end else begin
			ar = (r.active_rows > TILE_ROWS_DEF) ? TILE_ROWS_DEF : int'(r.active_rows);
			ac = (r.active_cols > TILE_COLS_DEF) ? TILE_COLS_DEF : int'(r.active_cols);
			res.in_range = (int'(r.row) < ar) && (int'(r.col) < ac);
			res.saturated = 1'b0;
			res.c_new = r.c_old;
			if (res.in_range) begin
				sum = $signed(r.c_old);
				sum = sum + longint'(tile_acc[r.row * 8 + r.col]);
				res.c_new = clip48(sum, hit);
				res.saturated = hit;
			end
			merge_results_q.push_back(res);
		end
	endtask

	// ---------------- request builders ----------------

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [15:0] pick_lane();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [63:0] rand_lanes();
		logic [63:0] w;
		for (int i = 0; i < 4; i++) w[i * 16 +: 16] = pick_lane();
		return w;
	endfunction

	// unused fields get junk so that the block must ignore them
	function automatic req_t mk_kstep(input logic first, input logic [63:0] alo,
			input logic [63:0] ahi, input logic [63:0] blo, input logic [63:0] bhi);
		req_t r;
		r = req_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom});
		r.req_type = REQ_KSTEP;
		r.first_step = first;
		r.a_rows_low = alo;
		r.a_rows_high = ahi;
		r.b_cols_low = blo;
		r.b_cols_high = bhi;
		return r;
	endfunction

	function automatic req_t mk_merge(input logic [2:0] row, input logic [2:0] col,
			input logic [3:0] ar, input logic [3:0] ac, input logic signed [47:0] c_old);
		req_t r;
		r = mk_kstep(1'($urandom), rand64(), rand64(), rand64(), rand64());
		r.req_type = REQ_MERGE;
		r.row = row;
		r.col = col;
		r.active_rows = ar;
		r.active_cols = ac;
		r.c_old = c_old;
		return r;
	endfunction

	function automatic logic signed [47:0] pick_c_old();
		longint off;
		off = longint'($urandom) << $urandom_range(0, 2);
		case ($urandom_range(9))
			0, 1: return 48'(ACC_HI - off);
			2, 3: return 48'(ACC_LO + off);
			default: return 48'(rand64());
		endcase
	endfunction

	function automatic logic [3:0] pick_active();
		if ($urandom_range(9) < 7) return 4'($urandom_range(1, 8));
		return 4'($urandom_range(0, 15));
	endfunction

	task automatic push_directed();
		logic [63:0] mix_a;
		logic [63:0] mix_b;
		mix_a = 64'hFFFF_0001_8000_7FFF;
		mix_b = 64'h7FFF_8000_FFFF_0000;
		// merges against the cleared tile, including active counts above the tile size
		request_q.push_back(mk_merge(3'd0, 3'd0, 4'd8, 4'd8, C_MAX));
		request_q.push_back(mk_merge(3'd7, 3'd7, 4'd15, 4'd15, C_MIN));
		request_q.push_back(mk_kstep(1'b1, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}},
			{4{16'h8000}}));
		request_q.push_back(mk_merge(3'd0, 3'd0, 4'd8, 4'd8, C_MAX));
		request_q.push_back(mk_merge(3'd7, 3'd7, 4'd9, 4'd9, 48'sd0));
		request_q.push_back(mk_kstep(1'b0, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h8000}},
			{4{16'h8000}}));
		request_q.push_back(mk_merge(3'd3, 3'd4, 4'd8, 4'd8, -48'sd1));
		request_q.push_back(mk_kstep(1'b1, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h8000}},
			{4{16'h8000}}));
		request_q.push_back(mk_merge(3'd5, 3'd2, 4'd8, 4'd8, C_MIN));
		// outside the active tile, plus one merge just inside its edge
		request_q.push_back(mk_merge(3'd0, 3'd0, 4'd0, 4'd8, 48'sd123));
		request_q.push_back(mk_merge(3'd0, 3'd0, 4'd8, 4'd0, 48'sd123));
		request_q.push_back(mk_merge(3'd7, 3'd0, 4'd7, 4'd8, C_MAX));
		request_q.push_back(mk_merge(3'd0, 3'd7, 4'd8, 4'd7, C_MIN));
		request_q.push_back(mk_merge(3'd6, 3'd6, 4'd7, 4'd7, 48'sd5));
		request_q.push_back(mk_kstep(1'b0, mix_a, ~mix_a, mix_b, ~mix_b));
		for (int r = 0; r < 8; r++)
			request_q.push_back(mk_merge(3'(r), 3'(7 - r), 4'd8, 4'd8, pick_c_old()));
	endtask

	// mostly k-step runs followed by merges; some loose random requests
	task automatic push_random(input int target);
		int made;
		int nk;
		int nm;
		req_t r;
		made = 0;
		while (made < target) begin
			if ($urandom_range(9) == 0) begin
				r = req_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom});
				request_q.push_back(r);
				made++;
			end else begin
				nk = $urandom_range(1, 4);
				nm = $urandom_range(1, 6);
				for (int k = 0; k < nk; k++) begin
					request_q.push_back(mk_kstep(
						(k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(15) == 0),
						rand_lanes(), rand_lanes(), rand_lanes(), rand_lanes()));
				end
				for (int k = 0; k < nm; k++) begin
					request_q.push_back(mk_merge(3'($urandom), 3'($urandom), pick_active(),
						pick_active(), pick_c_old()));
				end
				made += nk + nm;
			end
		end
	endtask

	// ---------------- sequence ----------------

	initial begin
		foreach (tile_acc[i]) tile_acc[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		for (int phase = 0; phase < 3; phase++) begin
			@(negedge clk);
			case (phase)
				0: begin
					send_idle_pct = 16;
					rcv_stall_pct = 50;
					push_directed();
				end
				1: begin
					send_idle_pct = 50;
					rcv_stall_pct = 16;
				end
				default: begin
					send_idle_pct = 0;
					rcv_stall_pct = 0;
				end
			endcase
			push_random(RAND_PER_PHASE);
			while (request_q.size() != 0 || req_valid) @(negedge clk);
		end
		while (merge_results_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatch_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// ---------------- request driver ----------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && !req_stall)
				apply_to_tile(req);
			if (!req_valid || !req_stall) begin
				if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req <= request_q.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------- result monitor ----------------

	task automatic flag_mismatch(input string what, input rsp_t want, input rsp_t got);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("%0t mismatch (%s): exp c_new=%0d in_range=%0b sat=%0b, got c_new=%0d in_range=%0b sat=%0b",
				$realtime, what, want.c_new, want.in_range, want.saturated, got.c_new,
				got.in_range, got.saturated);
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (merge_results_q.size() == 0) begin
					flag_mismatch("unexpected", '0, rsp);
				end else begin
					want = merge_results_q.pop_front();
					if (rsp.c_new !== want.c_new)
						flag_mismatch("c_new", want, rsp);
					else if (rsp.in_range !== want.in_range)
						flag_mismatch("in_range", want, rsp);
					else if (rsp.saturated !== want.saturated)
						flag_mismatch("saturated", want, rsp);
				end
			end
			rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
		end
	end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/mtopa_pkg.sv
hw/rtl/mtopa_row_mac.sv
hw/rtl/matmul_tile_outer_product_accumulate.sv
test/tb_top.sv
